/* design/bdlp_pkg.sv */
// shared types and constants for the button debounce and long press unit
`default_nettype none

package bdlp_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned APB_AW    = 3;

    localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST   = 16'd30;
    localparam logic [CFG_W-1:0] LONG_PRESS_TIME_RST = 16'd3000;

    typedef enum logic {
        REG_DEBOUNCE_TIME   = 1'b0,
        REG_LONG_PRESS_TIME = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        EVT_NONE  = 2'd0,
        EVT_SHORT = 2'd1,
        EVT_LONG  = 2'd2
    } press_event_t;

    typedef struct packed {
        logic              last_raw;
        logic              stable_level;
        logic [TIME_W-1:0] change_time;
        logic [TIME_W-1:0] press_start;
        logic              long_reported;
    } btn_state_t;

endpackage

`default_nettype wire

/* design/bdlp_eval.sv */
// per-sample debounce and press classification logic
`default_nettype none

module bdlp_eval
    import bdlp_pkg::*;
(
    input  wire btn_state_t        state_cur,
    input  wire logic [TIME_W-1:0] now,
    input  wire logic              raw,
    input  wire logic [CFG_W-1:0]  debounce_time,
    input  wire logic [CFG_W-1:0]  long_press_time,
    output btn_state_t             state_next,
    output press_event_t           event_code
);

    logic [TIME_W-1:0] chg_time;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_press;
    logic              settled;
    btn_state_t        edge_state;

    assign chg_time     = (raw != state_cur.last_raw) ? now : state_cur.change_time;
    assign since_change = now - chg_time;
    assign settled      = since_change >= {{(TIME_W-CFG_W){1'b0}}, debounce_time};
    assign since_press  = now - edge_state.press_start;

    always_comb begin
        edge_state             = state_cur;
        edge_state.last_raw    = raw;
        edge_state.change_time = chg_time;
        event_code             = EVT_NONE;
        if (settled && (state_cur.stable_level != raw)) begin
            edge_state.stable_level = raw;
            if (raw) begin
                edge_state.press_start   = now;
                edge_state.long_reported = 1'b0;
            end else if (!state_cur.long_reported) begin
                event_code = EVT_SHORT;
            end
        end
        state_next = edge_state;
        if (settled && edge_state.stable_level && !edge_state.long_reported &&
            (since_press >= {{(TIME_W-CFG_W){1'b0}}, long_press_time})) begin
            state_next.long_reported = 1'b1;
            event_code               = EVT_LONG;
        end
    end

endmodule

`default_nettype wire

/* design/button_debounce_long_press_unit.sv */
// Button debouncer with short and long press events. Each request carries a
// millisecond timestamp and the raw button level and yields one press_event
// (0 none, 1 short press released, 2 long press reached). The unit takes one
// request per clock cycle as long as m_ready takes each result: all
// evaluation is one pass of compare logic from the request port and the
// button state registers into the result register. The result register frees
// itself when taken, so a new request is taken in the same cycle a waiting
// result leaves. Debounce and long press times sit at APB byte addresses 0
// and 4; change them only while idle.
`default_nettype none

module button_debounce_long_press_unit
    import bdlp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [TIME_W-1:0] s_timestamp_ms,
    input  wire logic              s_raw_level,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_press_event,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    btn_state_t       state_reg;
    btn_state_t       state_next;
    press_event_t     event_next;
    press_event_t     event_reg;
    logic             m_valid_reg;
    logic [CFG_W-1:0] debounce_time_reg;
    logic [CFG_W-1:0] long_press_time_reg;
    logic             req_take;
    logic             cfg_write;
    reg_index_t       cfg_sel;

    assign s_ready   = !m_valid_reg || m_ready;
    assign req_take  = s_valid && s_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = reg_index_t'(paddr[2]);

    bdlp_eval u_eval (
        .state_cur       (state_reg),
        .now             (s_timestamp_ms),
        .raw             (s_raw_level),
        .debounce_time   (debounce_time_reg),
        .long_press_time (long_press_time_reg),
        .state_next      (state_next),
        .event_code      (event_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= '0;
            m_valid_reg         <= 1'b0;
            debounce_time_reg   <= DEBOUNCE_TIME_RST;
            long_press_time_reg <= LONG_PRESS_TIME_RST;
        end else begin
            if (req_take) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_write) begin
                case (cfg_sel)
                    REG_DEBOUNCE_TIME:   debounce_time_reg   <= pwdata[CFG_W-1:0];
                    REG_LONG_PRESS_TIME: long_press_time_reg <= pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_take) begin
            event_reg <= event_next;
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_DEBOUNCE_TIME:   prdata = {{(APB_DW-CFG_W){1'b0}}, debounce_time_reg};
            REG_LONG_PRESS_TIME: prdata = {{(APB_DW-CFG_W){1'b0}}, long_press_time_reg};
            default:             prdata = '0;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_press_event = event_reg;

    // long press is only reported on a held, now-latched press
    a_long_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_take && event_next == EVT_LONG) |=>
            (state_reg.stable_level && state_reg.long_reported))
        else $error("long press without latched pressed state");

    // short press only on a release that was not already long
    a_short_on_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_take && event_next == EVT_SHORT) |=>
            (!state_reg.stable_level && !$past(state_reg.long_reported)))
        else $error("short press on wrong edge");

    // a request the unit takes always leaves a result behind
    a_take_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        req_take |=> m_valid)
        else $error("accepted request produced no result");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
